// ----- sv/sorted_priority_queue_top_macros.svh -----
// assertion macros for the sorted priority queue
// no dependencies; included by files that carry assertions
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define SPQ_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
`define SPQ_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define SPQ_ASSERT_IMPLY(label, clk, rst, cond, prop, msg)
`define SPQ_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

// ----- sv/spq_pkg.sv -----
// types and constants shared by the sorted priority queue
// no dependencies
`timescale 1ns / 1ps
package spq_pkg;

  localparam int PRIO_W = 8;
  localparam int PID_W  = 22;
  localparam int OCC_W  = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [PID_W-1:0]  pid;
  } slot_t;

  typedef struct packed {
    op_t               op;
    logic [PRIO_W-1:0] prio;
    logic [PID_W-1:0]  pid;
  } cmd_t;

  typedef struct packed {
    logic stay;
    logic found;
  } link_t;

endpackage

// ----- sv/spq_cell.sv -----
// one slot of the sorted chain: holds an entry, shifts right on insert, left on remove
// depends on spq_pkg
`timescale 1ns / 1ps
module spq_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           apply_ins,
  input  logic           apply_rem,
  input  spq_pkg::cmd_t  cmd,
  input  logic [CW-1:0]  count,
  input  spq_pkg::slot_t left_slot,
  input  spq_pkg::link_t left_link,
  input  spq_pkg::slot_t right_slot,
  output spq_pkg::slot_t slot,
  output spq_pkg::link_t link
);
  import spq_pkg::*;

  logic occupied;
  logic match;

  assign occupied   = count > CW'(IDX);
  assign link.stay  = occupied && (slot.prio > cmd.prio);
  assign match      = occupied && (slot.pid == cmd.pid);
  assign link.found = left_link.found | match;

  always_ff @(posedge clk) begin
    if (apply_ins && !link.stay) begin
      if (left_link.stay) begin
        slot.prio <= cmd.prio;
        slot.pid  <= cmd.pid;
      end else begin
        slot <= left_slot;
      end
    end else if (apply_rem && link.found) begin
      slot <= right_slot;
    end
  end

endmodule

// ----- sv/sorted_priority_queue_top.sv -----
// sorted priority queue: one command per cycle, result strobed on done in the cycle after accept
// throughput 1 command per cycle, busy only in reset
// all cells compare in parallel; remove match ripples through the row of cells
// synchronous active-high reset empties the queue; slot contents stay undefined until written
// the receiver cannot stall: each result shows for exactly one cycle
// depends on spq_pkg, spq_cell and sorted_priority_queue_top_macros.svh
`timescale 1ns / 1ps
`include "sorted_priority_queue_top_macros.svh"
module sorted_priority_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      func,
  input  logic [spq_pkg::PRIO_W-1:0] priority_req,
  input  logic [spq_pkg::PID_W-1:0]  pid,
  output logic                      done,
  output logic [1:0]                status,
  output logic                      head_valid,
  output logic [spq_pkg::PRIO_W-1:0] head_priority,
  output logic [spq_pkg::PID_W-1:0]  head_pid,
  output logic [spq_pkg::OCC_W-1:0]  occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  cmd_t           cmd;
  logic           accept;
  logic           full;
  logic           apply_ins;
  logic           apply_rem;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  status_t        result_status;
  status_t        result_status_next;
  slot_t          slots [DEPTH];
  link_t          links [DEPTH];
  logic [CW+OCC_W-1:0] count_ext;

  assign busy    = rst;
  assign accept  = start && !busy;
  assign cmd.op  = op_t'(func);
  assign cmd.prio = priority_req;
  assign cmd.pid = pid;
  assign full    = count == CW'(DEPTH);

  assign apply_ins = accept && (cmd.op == OP_INSERT) && !full;
  assign apply_rem = accept && (cmd.op == OP_REMOVE) && links[DEPTH-1].found;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      slot_t left_slot;
      link_t left_link;
      slot_t right_slot;
      if (i == 0) begin : g_first
        assign left_slot = '0;
        assign left_link = '{stay: 1'b1, found: 1'b0};
      end else begin : g_mid
        assign left_slot = slots[i-1];
        assign left_link = links[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_slot = '0;
      end else begin : g_body
        assign right_slot = slots[i+1];
      end
      spq_cell #(
        .CW  (CW),
        .IDX (i)
      ) u_cell (
        .clk        (clk),
        .apply_ins  (apply_ins),
        .apply_rem  (apply_rem),
        .cmd        (cmd),
        .count      (count),
        .left_slot  (left_slot),
        .left_link  (left_link),
        .right_slot (right_slot),
        .slot       (slots[i]),
        .link       (links[i])
      );
    end
  endgenerate

  always_comb begin
    count_next         = count;
    result_status_next = ST_DONE;
    if (accept) begin
      case (cmd.op)
        OP_INSERT: begin
          if (full) begin
            result_status_next = ST_FULL;
          end else begin
            count_next = count + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (links[DEPTH-1].found) begin
            count_next = count - 1'b1;
          end else begin
            result_status_next = ST_NOT_FOUND;
          end
        end
        default: result_status_next = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    result_status <= result_status_next;
  end

  assign count_ext     = {{OCC_W{1'b0}}, count};
  assign status        = result_status;
  assign head_valid    = count != '0;
  assign head_priority = head_valid ? slots[0].prio : '0;
  assign head_pid      = head_valid ? slots[0].pid : '0;
  assign occupancy     = count_ext[OCC_W-1:0];

  `SPQ_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "count above depth")
  `SPQ_ASSERT_NEXT(a_done_follows, clk, rst, accept, done, "done missing after accept")
  `SPQ_ASSERT_NEXT(a_insert_grows, clk, rst, apply_ins, count == $past(count) + 1'b1, "insert count")
  `SPQ_ASSERT_IMPLY(a_full_status, clk, rst, done && (result_status == ST_FULL), count == CW'(DEPTH), "full status with room")
  `SPQ_ASSERT_NEXT(a_miss_keeps, clk, rst, accept && (cmd.op == OP_REMOVE) && !links[DEPTH-1].found, $stable(count), "miss changed count")

endmodule
